// ===== rtl/simon_pkg.sv =====
// Shared types and constants for the Simon128/256 block cipher.
// Depends on nothing; the cipher top, the checker and the testbench import it.
`timescale 1ns / 1ps

package simon_pkg;

   localparam int unsigned ROUNDS         = 72;
   localparam int unsigned WORD_BITS      = 64;
   localparam int unsigned KEY_WORDS      = 4;
   localparam int unsigned Z_PERIOD       = 62;
   localparam int unsigned ROUND_BITS     = $clog2(ROUNDS);
   localparam int unsigned KEY_SEL_BITS   = $clog2(KEY_WORDS);
   localparam int unsigned Z_IDX_BITS     = $clog2(Z_PERIOD);
   localparam int unsigned CSR_INDEX_BITS = 3;

   // z4 sequence; element j is bit (Z_PERIOD - 1 - j) of this word.
   localparam logic [63:0] Z4_SEQ = 64'h3479_AD88_170C_A4EF;
   // Constant 3 folded into every expanded round key.
   localparam logic [63:0] KEY_CONST = 64'd3;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_WORD_3 = 3'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic     opcode;
      word_type block_x;
      word_type block_y;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
   } rsp_type;

endpackage

// ===== rtl/simon_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the round key store.
`timescale 1ns / 1ps

module simon_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/simon_block_cipher_top.sv =====
// Simon128/256 block cipher: 128-bit words as two 64-bit halves, 256-bit key in four
// 64-bit key registers. After reset, and after every write to a key register, the block
// expands the 72 round keys into its key RAM, one key per cycle; during that time
// req_ready is low, while csr writes are still taken (a new write restarts the
// expansion). A word is then accepted only while the engine is idle. The engine runs one
// round per cycle, reading one round key per cycle from the key RAM's single read port,
// then loads the result into the result register once that register is free and returns
// to idle, so a new word is accepted only after the last one has left the engine. The
// result register lets the next word be accepted while an earlier result still waits on rsp_ready.
// Depends on simon_pkg and simon_ram.
`timescale 1ns / 1ps

module simon_block_cipher_top
   import simon_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_RUN,
      ST_DONE
   } state_type;

   function automatic word_type rotl(input word_type v, input int unsigned s);
      return (v << s) | (v >> (WORD_BITS - s));
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned s);
      return (v >> s) | (v << (WORD_BITS - s));
   endfunction

   function automatic word_type round_f(input word_type v);
      return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
   endfunction

   state_type              state_ff, state_in;
   logic [ROUND_BITS-1:0]  cnt_ff, cnt_in;
   logic [Z_IDX_BITS-1:0]  zidx_ff, zidx_in;
   logic                   decrypt_ff, decrypt_in;
   word_type               x_ff, x_in;
   word_type               y_ff, y_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   word_type               key_ff [KEY_WORDS];
   // Sliding window of the last four round keys written: win_ff[0] is the oldest.
   word_type               win_ff [KEY_WORDS];

   logic                   key_write;
   logic                   req_fire;
   logic                   ram_wr_en;
   logic [ROUND_BITS-1:0]  ram_rd_addr;
   word_type               ram_wr_data;
   word_type               ram_rd_data;
   word_type               exp_t0;
   word_type               exp_t;
   word_type               exp_key;
   logic                   z_bit;

   assign csr_ready = 1'b1;
   assign key_write = csr_valid && (csr_index < CSR_INDEX_BITS'(KEY_WORDS));
   // A pending key write wins over a new word, so the two never meet in one cycle.
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Key schedule step from the window.
   assign z_bit   = Z4_SEQ[Z_IDX_BITS'(Z_PERIOD - 1) - zidx_ff];
   assign exp_t0  = rotr(win_ff[3], 3) ^ win_ff[1];
   assign exp_t   = exp_t0 ^ rotr(exp_t0, 1);
   assign exp_key = ~win_ff[0] ^ exp_t ^ WORD_BITS'(z_bit) ^ WORD_BITS'(KEY_CONST);

   assign ram_wr_en   = (state_ff == ST_EXPAND);
   assign ram_wr_data = (cnt_ff < ROUND_BITS'(KEY_WORDS)) ? key_ff[cnt_ff[KEY_SEL_BITS-1:0]]
                                                          : exp_key;

   // The key for the next round is read from the RAM in the cycle before its use.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = (req_data.opcode == OP_DECRYPT) ? ROUND_BITS'(ROUNDS - 1)
                                                        : '0;
      end else if (decrypt_ff) begin
         ram_rd_addr = ROUND_BITS'(ROUNDS - 2) - cnt_ff;
      end else begin
         ram_rd_addr = cnt_ff + ROUND_BITS'(1);
      end
   end

   simon_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROUNDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      zidx_in      = zidx_ff;
      decrypt_in   = decrypt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               decrypt_in = (req_data.opcode == OP_DECRYPT);
               x_in       = req_data.block_x;
               y_in       = req_data.block_y;
               cnt_in     = '0;
               state_in   = ST_RUN;
            end
         end
         ST_EXPAND: begin
            if (cnt_ff >= ROUND_BITS'(KEY_WORDS)) begin
               zidx_in = (zidx_ff == Z_IDX_BITS'(Z_PERIOD - 1)) ? '0
                                                               : zidx_ff + Z_IDX_BITS'(1);
            end
            if (cnt_ff == ROUND_BITS'(ROUNDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ROUND_BITS'(1);
            end
         end
         ST_RUN: begin
            if (decrypt_ff) begin
               y_in = x_ff ^ round_f(y_ff) ^ ram_rd_data;
               x_in = y_ff;
            end else begin
               x_in = y_ff ^ round_f(x_ff) ^ ram_rd_data;
               y_in = x_ff;
            end
            if (cnt_ff == ROUND_BITS'(ROUNDS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ROUND_BITS'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.out_x = x_ff;
               rsp_data_in.out_y = y_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Any key write restarts the schedule from round key zero.
      if (key_write) begin
         state_in = ST_EXPAND;
         cnt_in   = '0;
         zidx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EXPAND;
         cnt_ff       <= '0;
         zidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         zidx_ff      <= zidx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (key_write) begin
            key_ff[csr_index[KEY_SEL_BITS-1:0]] <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      decrypt_ff  <= decrypt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
      if (ram_wr_en) begin
         for (int i = 0; i < KEY_WORDS - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[KEY_WORDS-1] <= ram_wr_data;
      end
   end

endmodule

// ===== rtl/simon_checker.sv =====
// Port-level checks for simon_block_cipher_top, attached by the bind at the end.
// Depends on simon_pkg.
`timescale 1ns / 1ps

module simon_checker
   import simon_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rsp_type                   rsp_data,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [CSR_INDEX_BITS-1:0] csr_index
);

   // A result word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the word was taken");

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // The engine holds one word at a time: it is busy right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted word");

   // A key write starts a new key schedule, which blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index < CSR_INDEX_BITS'(KEY_WORDS)) |=> !req_ready)
      else $error("req_ready high right after a key write");

endmodule

bind simon_block_cipher_top simon_checker u_checker (.*);

// ===== tb/simon_block_cipher_top_tb.sv =====
// Self-checking testbench for simon_block_cipher_top: a Simon128/256 model in the scoreboard
// predicts every encrypted or decrypted word, which is checked against the block's results.
// Depends on simon_pkg and the block's RTL.
`timescale 1ns / 1ps

module simon_block_cipher_top_tb;
   import simon_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 800_000;
   localparam int unsigned PHASES        = 16;
   localparam int unsigned PHASE_WORDS   = 100;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned DRAIN_LIMIT   = 20_000;
   localparam int unsigned SCHED_PERIOD  = 62;
   localparam logic [63:0] SCHED_SEQ     = 64'h3479_AD88_170C_A4EF;
   localparam word_type    SCHED_CONST   = 64'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HIGH = 3'd7;

   class cipher_scoreboard;
      word_type    key_words[KEY_WORDS];
      word_type    round_keys[ROUNDS];
      rsp_type     expected_blocks[$];
      int unsigned error_count;

      function new();
         foreach (key_words[i]) key_words[i] = '0;
         error_count = 0;
         expand_round_keys();
      endfunction

      static function word_type rotl(word_type v, int unsigned s);
         return (v << s) | (v >> (WORD_BITS - s));
      endfunction

      static function word_type rotr(word_type v, int unsigned s);
         return (v >> s) | (v << (WORD_BITS - s));
      endfunction

      static function word_type mix(word_type v);
         return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
      endfunction

      function void expand_round_keys();
         word_type    t;
         int unsigned j;
         foreach (key_words[i]) round_keys[i] = key_words[i];
         for (int unsigned i = KEY_WORDS; i < ROUNDS; i++) begin
            j = (i - KEY_WORDS) % SCHED_PERIOD;
            t = rotr(round_keys[i-1], 3) ^ round_keys[i-3];
            t = t ^ rotr(t, 1);
            round_keys[i] = ~round_keys[i-KEY_WORDS] ^ t ^ SCHED_CONST
                            ^ word_type'(SCHED_SEQ[SCHED_PERIOD-1-j]);
         end
      endfunction

      // Writes to indexes beyond the key words leave the schedule untouched.
      function void load_key_word(logic [CSR_INDEX_BITS-1:0] idx, word_type val);
         case (idx)
            CSR_KEY_WORD_0: key_words[0] = val;
            CSR_KEY_WORD_1: key_words[1] = val;
            CSR_KEY_WORD_2: key_words[2] = val;
            CSR_KEY_WORD_3: key_words[3] = val;
            default: return;
         endcase
         expand_round_keys();
      endfunction

      function rsp_type cipher_block(req_type r);
         word_type x, y, t;
         rsp_type  res;
         x = r.block_x;
         y = r.block_y;
         if (r.opcode == OP_ENCRYPT) begin
            for (int unsigned i = 0; i < ROUNDS; i++) begin
               t = x;
               x = y ^ mix(x) ^ round_keys[i];
               y = t;
            end
         end else begin
            for (int unsigned i = ROUNDS; i > 0; i--) begin
               t = y;
               y = x ^ mix(y) ^ round_keys[i-1];
               x = t;
            end
         end
         res.out_x = x;
         res.out_y = y;
         return res;
      endfunction

      function int unsigned pending();
         return expected_blocks.size();
      endfunction

      task report_mismatch(string msg);
         error_count++;
         $display("mismatch: %s", msg);
      endtask

      task note_request(req_type r);
         expected_blocks.push_back(cipher_block(r));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("result %h with no word outstanding", got));
         end else begin
            want = expected_blocks.pop_front();
            if (got.out_x !== want.out_x)
               report_mismatch($sformatf("out_x %h, expected %h", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
               report_mismatch($sformatf("out_y %h, expected %h", got.out_y, want.out_y));
         end
      endtask

      task flush_leftover();
         if (expected_blocks.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
            expected_blocks.delete();
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   word_type                  csr_data;

   cipher_scoreboard board;
   bit               idle_on;

   simon_block_cipher_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned draw_idle();
      return idle_on ? $urandom_range(0, 6) : 0;
   endfunction

   function automatic word_type random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CSR_INDEX_BITS-1:0] key_index(int unsigned k);
      case (k)
         0: return CSR_KEY_WORD_0;
         1: return CSR_KEY_WORD_1;
         2: return CSR_KEY_WORD_2;
         default: return CSR_KEY_WORD_3;
      endcase
   endfunction

   // Valid stays high across back-to-back words; it drops only when a gap is drawn or results are drained.
   task automatic send_word(logic op, word_type x, word_type y);
      req_type     blk;
      int unsigned gap;
      blk.opcode  = op;
      blk.block_x = x;
      blk.block_y = y;
      gap = draw_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= blk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(blk);
   endtask

   // The caller lowers csr_valid after the last write of a batch.
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, word_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.load_key_word(idx, val);
   endtask

   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      board.flush_leftover();
   endtask

   task automatic run_directed();
      // All-zero key straight out of reset.
      send_word(OP_ENCRYPT, '0, '0);
      send_word(OP_DECRYPT, '0, '0);
      send_word(OP_ENCRYPT, '1, '1);
      send_word(OP_DECRYPT, '1, '1);
      send_word(OP_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_word(OP_DECRYPT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_ENCRYPT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      send_word(OP_DECRYPT, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
      drain_results();
      write_csr(CSR_KEY_WORD_0, 64'h0706_0504_0302_0100);
      write_csr(CSR_KEY_WORD_1, 64'h0F0E_0D0C_0B0A_0908);
      write_csr(CSR_KEY_WORD_2, 64'h1716_1514_1312_1110);
      write_csr(CSR_KEY_WORD_3, 64'h1F1E_1D1C_1B1A_1918);
      // Unused indexes must not disturb the key just loaded.
      write_csr(CSR_UNUSED_LOW, '1);
      write_csr(CSR_UNUSED_HIGH, 64'h0123_4567_89AB_CDEF);
      csr_valid <= 1'b0;
      send_word(OP_ENCRYPT, 64'h7420_6E69_206D_6F6F, 64'h6D69_7320_6120_7369);
      send_word(OP_DECRYPT, 64'h8D2B_5579_AFC8_A3A0, 64'h3BF7_2A87_EFE7_B868);
      send_word(OP_ENCRYPT, '0, '1);
      send_word(OP_DECRYPT, '1, '0);
      send_word(OP_ENCRYPT, 64'h0000_0000_0000_0001, '0);
      send_word(OP_DECRYPT, '0, 64'h8000_0000_0000_0000);
   endtask

   // Phase 0 and 1 load the all-zero and all-one keys; later phases change
   // a random subset of key words; any phase sometimes pokes an unused index.
   task automatic configure_phase(int unsigned p);
      for (int unsigned k = 0; k < KEY_WORDS; k++) begin
         if (p == 0) write_csr(key_index(k), '0);
         else if (p == 1) write_csr(key_index(k), '1);
         else if ($urandom_range(0, 1) == 1) write_csr(key_index(k), random_word());
      end
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_LOW, CSR_UNUSED_HIGH)),
                   random_word());
      csr_valid <= 1'b0;
   endtask

   initial begin
      board   = new();
      idle_on = 1'b1;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int unsigned p = 0; p < PHASES; p++) begin
         drain_results();
         // Every fourth phase runs both sides without idle cycles.
         idle_on = (p % 4) != 3;
         configure_phase(p);
         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            send_word($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
                      random_word(), random_word());
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Result side: a stall holds ready low until a word is waiting, then a few cycles more.
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_idle();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_response(rsp_data);
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/simon_pkg.sv
rtl/simon_ram.sv
rtl/simon_block_cipher_top.sv
rtl/simon_checker.sv
tb/simon_block_cipher_top_tb.sv
